@@ hw/rtl/rdcd_pkg.sv @@
`timescale 1ns / 1ps

package rdcd_pkg;

  localparam int unsigned TickCountWidthDef = 16;

  // configuration port
  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [2:0] {
    REG_SPEED_LEVEL_0   = 3'd0,
    REG_SPEED_LEVEL_1   = 3'd1,
    REG_SPEED_LEVEL_2   = 3'd2,
    REG_SPEED_LEVEL_3   = 3'd3,
    REG_SPEED_COUNT     = 3'd4,
    REG_COAST_DELAY     = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_FWD        = 3'd1,
    ACT_REV        = 3'd2,
    ACT_LEFT       = 3'd3,
    ACT_RIGHT      = 3'd4,
    ACT_CORR_RIGHT = 3'd5,
    ACT_CORR_LEFT  = 3'd6,
    ACT_COAST      = 3'd7
  } action_e;

  typedef enum logic [3:0] {
    EV_NONE    = 4'd0,
    EV_MENU    = 4'd1,
    EV_SPEED   = 4'd2,
    EV_MODE    = 4'd3,
    EV_IGNORED = 4'd4,
    EV_UNKNOWN = 4'd5,
    EV_MOTION  = 4'd6,
    EV_TIMEOUT = 4'd7,
    EV_REFRESH = 4'd8
  } evt_e;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_AUTO   = 2'd1,
    MODE_SLAVE  = 2'd2,
    MODE_MANUAL = 2'd3
  } mode_e;

  // ascii codes
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_LF      = 8'h0a;
  localparam logic [7:0] CHAR_CR      = 8'h0d;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_ONE     = 8'h31;
  localparam logic [7:0] CHAR_FOUR    = 8'h34;
  localparam logic [7:0] CHAR_B       = 8'h42;
  localparam logic [7:0] CHAR_C       = 8'h43;
  localparam logic [7:0] CHAR_F       = 8'h46;
  localparam logic [7:0] CHAR_G       = 8'h47;
  localparam logic [7:0] CHAR_H       = 8'h48;
  localparam logic [7:0] CHAR_L       = 8'h4c;
  localparam logic [7:0] CHAR_R       = 8'h52;
  localparam logic [7:0] CHAR_S       = 8'h53;
  localparam logic [7:0] CHAR_U       = 8'h55;
  localparam logic [7:0] CHAR_W       = 8'h57;
  localparam logic [7:0] CHAR_X       = 8'h58;
  localparam logic [7:0] CHAR_A_LO    = 8'h61;
  localparam logic [7:0] CHAR_U_LO    = 8'h75;
  localparam logic [7:0] CHAR_W_LO    = 8'h77;
  localparam logic [7:0] CHAR_X_LO    = 8'h78;
  localparam logic [7:0] CHAR_Z_LO    = 8'h7a;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  localparam logic [2:0] SpeedCountMax = 3'd4;

  typedef struct packed {
    logic [3:0][7:0] speed_level;
    logic [2:0]      speed_count;
    logic [15:0]     coast_delay;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    speed_level: {8'd255, 8'd192, 8'd128, 8'd64},
    speed_count: 3'd4,
    coast_delay: 16'd500
  };

  // control state apart from the tick counter
  typedef struct packed {
    mode_e      mode;
    logic       menu;
    logic       selected;
    logic [1:0] speed_index;
    logic [7:0] active_motion;
    logic [7:0] last_motion;
  } ctl_t;

  localparam ctl_t CtlReset = '{
    mode:          MODE_NONE,
    menu:          1'b1,
    selected:      1'b0,
    speed_index:   2'd0,
    active_motion: 8'd0,
    last_motion:   8'd0
  };

  // packed as on the output stream, drive_action in the lowest bits
  typedef struct packed {
    logic [3:0] pad;
    evt_e       event_res;
    logic       mode_selected;
    logic       menu_active;
    mode_e      mode;
    logic [7:0] speed_value;
    logic       speed_write;
    action_e    drive_action;
  } result_t;

  function automatic action_e motion_action(input logic [7:0] c);
    action_e a;
    unique case (c)
      CHAR_F:         a = ACT_FWD;
      CHAR_B:         a = ACT_REV;
      CHAR_L:         a = ACT_LEFT;
      CHAR_R:         a = ACT_RIGHT;
      CHAR_H:         a = ACT_CORR_RIGHT;
      CHAR_G:         a = ACT_CORR_LEFT;
      CHAR_S, CHAR_C: a = ACT_COAST;
      default:        a = ACT_NONE;
    endcase
    return a;
  endfunction

endpackage

@@ hw/rtl/remote_drive_command_decoder.sv @@
`timescale 1ns / 1ps

// Remote drive command decoder. Each request on the input stream is either a
// received byte (tuser low, byte in tdata) or a one millisecond tick (tuser
// high) and yields exactly one result on the output stream. A request is
// registered on entry, decoded against the mode, speed and motion state in a
// single stage and the result is held in an output register, so one request
// is taken every clock cycle while m_axis_tready does not hold the output.
// The one decode stage that reads and updates the state sets that rate. The
// user must write speed table, speed count and stop delay over the APB port
// only while the stream is quiet; the block does not enforce this. No
// clearing pass after reset.
module remote_drive_command_decoder #(
  parameter int unsigned TickCountWidth = rdcd_pkg::TickCountWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // rx_byte
  input  logic                           s_axis_tuser,  // command
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // drive_action[2:0], speed_write[3], speed_value[11:4], mode[13:12],
  // menu_active[14], mode_selected[15], event_res[19:16], zero[23:20]
  output logic [23:0]                    m_axis_tdata,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rdcd_pkg::CfgAddrW-1:0]  paddr,
  input  logic [rdcd_pkg::CfgDataW-1:0]  pwdata,
  output logic [rdcd_pkg::CfgDataW-1:0]  prdata,
  output logic                           pready
);
  import rdcd_pkg::*;

  cfg_t                      cfg;
  logic                      in_valid_q, in_valid_d;
  logic                      in_cmd_q;
  logic [7:0]                in_byte_q;
  logic                      out_valid_q, out_valid_d;
  result_t                   res_q, res_d;
  ctl_t                      ctl_q, ctl_d;
  logic [TickCountWidth-1:0] elapsed_q, elapsed_d;
  logic                      proc;

  rdcd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rdcd_decoder #(
    .TickCountWidth (TickCountWidth)
  ) u_dec (
    .cfg_i     (cfg),
    .ctl_i     (ctl_q),
    .elapsed_i (elapsed_q),
    .command_i (in_cmd_q),
    .rx_byte_i (in_byte_q),
    .ctl_o     (ctl_d),
    .elapsed_o (elapsed_d),
    .res_o     (res_d)
  );

  // decode moves on whenever the result register is free or being emptied
  assign proc          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc;
  assign in_valid_d    = s_axis_tready ? s_axis_tvalid : in_valid_q;
  assign out_valid_d   = proc ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ctl_q       <= CtlReset;
      elapsed_q   <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (proc) begin
        ctl_q     <= ctl_d;
        elapsed_q <= elapsed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd_q  <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
    if (proc) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;

  // the menu flag and the selected flag are always complements
  a_menu_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q.menu != ctl_q.selected)
    else $error("menu and selected flags agree");

  // in the menu no mode is in force
  a_menu_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q.menu |-> ctl_q.mode == MODE_NONE)
    else $error("mode set while menu active");

  // the applied motion tracks the active motion
  a_motion_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q.active_motion == ctl_q.last_motion)
    else $error("applied motion differs from active motion");

  // a timeout leaves no active motion behind
  a_timeout_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && res_d.event_res == EV_TIMEOUT |=> ctl_q.active_motion == 8'd0)
    else $error("motion survives timeout");

  // a speed write is only issued with a speed event
  a_speed_evt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.speed_write |-> res_q.event_res == EV_SPEED)
    else $error("speed write without speed event");

endmodule

@@ hw/rtl/rdcd_cfg_regs.sv @@
`timescale 1ns / 1ps

module rdcd_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rdcd_pkg::CfgAddrW-1:0]   paddr,
  input  logic [rdcd_pkg::CfgDataW-1:0]   pwdata,
  output logic [rdcd_pkg::CfgDataW-1:0]   prdata,
  output logic                            pready,
  output rdcd_pkg::cfg_t                  cfg_o
);
  import rdcd_pkg::*;

  cfg_t     cfg_q, cfg_d;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[CfgAddrW-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_SPEED_LEVEL_0: cfg_d.speed_level[0] = pwdata[7:0];
        REG_SPEED_LEVEL_1: cfg_d.speed_level[1] = pwdata[7:0];
        REG_SPEED_LEVEL_2: cfg_d.speed_level[2] = pwdata[7:0];
        REG_SPEED_LEVEL_3: cfg_d.speed_level[3] = pwdata[7:0];
        REG_SPEED_COUNT:   cfg_d.speed_count    = pwdata[2:0];
        REG_COAST_DELAY:   cfg_d.coast_delay    = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SPEED_LEVEL_0: prdata = CfgDataW'(cfg_q.speed_level[0]);
      REG_SPEED_LEVEL_1: prdata = CfgDataW'(cfg_q.speed_level[1]);
      REG_SPEED_LEVEL_2: prdata = CfgDataW'(cfg_q.speed_level[2]);
      REG_SPEED_LEVEL_3: prdata = CfgDataW'(cfg_q.speed_level[3]);
      REG_SPEED_COUNT:   prdata = CfgDataW'(cfg_q.speed_count);
      REG_COAST_DELAY:   prdata = CfgDataW'(cfg_q.coast_delay);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/rdcd_decoder.sv @@
`timescale 1ns / 1ps

module rdcd_decoder #(
  parameter int unsigned TickCountWidth = rdcd_pkg::TickCountWidthDef
) (
  input  rdcd_pkg::cfg_t              cfg_i,
  input  rdcd_pkg::ctl_t              ctl_i,
  input  logic [TickCountWidth-1:0]   elapsed_i,
  input  logic                        command_i,
  input  logic [7:0]                  rx_byte_i,
  output rdcd_pkg::ctl_t              ctl_o,
  output logic [TickCountWidth-1:0]   elapsed_o,
  output rdcd_pkg::result_t           res_o
);
  import rdcd_pkg::*;

  localparam int unsigned CmpW = (TickCountWidth > 16) ? TickCountWidth : 16;
  localparam logic [TickCountWidth-1:0] TickMax = {TickCountWidth{1'b1}};

  logic [TickCountWidth-1:0] elapsed_inc;
  logic [CmpW-1:0]           elapsed_ext;
  logic [CmpW-1:0]           delay_ext;
  logic [7:0]                c;
  logic [2:0]                cnt;
  logic [2:0]                idx;
  action_e                   act;

  always_comb begin
    ctl_o       = ctl_i;
    elapsed_o   = elapsed_i;
    res_o       = '0;
    res_o.drive_action = ACT_NONE;
    res_o.event_res    = EV_NONE;
    elapsed_inc = (elapsed_i == TickMax) ? elapsed_i : elapsed_i + 1'b1;
    elapsed_ext = CmpW'(elapsed_inc);
    delay_ext   = CmpW'(cfg_i.coast_delay);
    c           = rx_byte_i;
    cnt         = cfg_i.speed_count;
    idx         = 3'(rx_byte_i - CHAR_ONE);
    act         = ACT_NONE;

    if (rx_byte_i >= CHAR_A_LO && rx_byte_i <= CHAR_Z_LO) begin
      c = rx_byte_i - CASE_OFFSET;
    end
    if (cnt == 3'd0) begin
      cnt = 3'd1;
    end else if (cnt > SpeedCountMax) begin
      cnt = SpeedCountMax;
    end
    if (idx >= cnt) begin
      idx = cnt - 3'd1;
    end

    if (command_i) begin
      elapsed_o = elapsed_inc;
      if (ctl_i.active_motion != 8'd0 && elapsed_ext > delay_ext) begin
        res_o.drive_action  = ACT_COAST;
        res_o.event_res     = EV_TIMEOUT;
        ctl_o.active_motion = 8'd0;
        ctl_o.last_motion   = 8'd0;
      end
    end else if (rx_byte_i == CHAR_CR || rx_byte_i == CHAR_LF ||
                 rx_byte_i == CHAR_SPACE || rx_byte_i == CHAR_NUL) begin
      res_o.event_res = EV_IGNORED;
    end else if (rx_byte_i == CHAR_W_LO || rx_byte_i == CHAR_X_LO ||
                 rx_byte_i == CHAR_U_LO) begin
      ctl_o.mode      = MODE_NONE;
      ctl_o.menu      = 1'b1;
      ctl_o.selected  = 1'b0;
      res_o.event_res = EV_MENU;
    end else if (c >= CHAR_ONE && c <= CHAR_FOUR) begin
      ctl_o.speed_index  = idx[1:0];
      res_o.speed_write  = 1'b1;
      res_o.speed_value  = cfg_i.speed_level[idx[1:0]];
      res_o.event_res    = EV_SPEED;
    end else if (c == CHAR_W || c == CHAR_X || c == CHAR_U) begin
      ctl_o.mode      = (c == CHAR_W) ? MODE_AUTO :
                        (c == CHAR_X) ? MODE_SLAVE : MODE_MANUAL;
      ctl_o.menu      = 1'b0;
      ctl_o.selected  = 1'b1;
      res_o.event_res = EV_MODE;
    end else if (ctl_i.mode != MODE_MANUAL) begin
      res_o.event_res = EV_IGNORED;
    end else begin
      ctl_o.active_motion = c;
      elapsed_o           = '0;
      if (c != ctl_i.last_motion) begin
        act                = motion_action(c);
        res_o.drive_action = act;
        res_o.event_res    = (act != ACT_NONE) ? EV_MOTION : EV_UNKNOWN;
        ctl_o.last_motion  = c;
      end else begin
        res_o.event_res = EV_REFRESH;
      end
    end

    res_o.mode          = ctl_o.mode;
    res_o.menu_active   = ctl_o.menu;
    res_o.mode_selected = ctl_o.selected;
  end

endmodule
